FILE: hdl/dbba_pkg.sv
// dbba_pkg: shared constants and result codes for the disk block bitmap allocator
// used by disk_block_bitmap_allocator_core, depends on nothing
`default_nettype none

package dbba_pkg;

  // fixed field widths
  localparam int BLK_W = 6;
  localparam int REQ_W = 4;
  localparam int KIND_W = 3;

  // parameter defaults
  localparam int DISK_BLOCKS_DEF = 64;
  localparam int MAX_FILE_BLOCKS_DEF = 10;

  // reset value of the default request size
  localparam logic [REQ_W-1:0] DEF_REQ_RST = 4'd3;

  // operation codes
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_DATA    = 3'd0,
    KIND_INDEX   = 3'd1,
    KIND_NOINDEX = 3'd2,
    KIND_FULL    = 3'd3,
    KIND_FREED   = 3'd4
  } kind_t;

endpackage

`default_nettype wire

FILE: hdl/disk_block_bitmap_allocator_core.sv
// disk_block_bitmap_allocator_core: first-fit bitmap block allocator, top level
// depends on dbba_pkg and dbba_map
//
//   channel  direction  handshake              payload
//   in_      request    in_valid / in_stall    func, request_count, free_block
//   out_     result     out_valid / out_stall  kind, block_number, contig_found,
//                                              run_start, last
//   cfg_     write      cfg_we                 cfg_wdata (default request size)
//
// a free request gives one result
// an allocate request scans the map through the single read port of the
// block memory: a first pass for the run and free count, then, unless the
// disk is full, a second pass marking data and index blocks that may end early
// after reset a clearing pass zeroes the map; no request is taken meanwhile,
// cfg writes are taken always
// a stalled result holds the scan; the next request is taken only when the
// result register can accept its first result
`default_nettype none

module disk_block_bitmap_allocator_core #(
  parameter int DISK_BLOCKS = dbba_pkg::DISK_BLOCKS_DEF,
  parameter int MAX_FILE_BLOCKS = dbba_pkg::MAX_FILE_BLOCKS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_func,
  input  wire logic [dbba_pkg::REQ_W-1:0]  in_request_count,
  input  wire logic [dbba_pkg::BLK_W-1:0]  in_free_block,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [dbba_pkg::KIND_W-1:0]      out_kind,
  output logic [dbba_pkg::BLK_W-1:0]       out_block_number,
  output logic                             out_contig_found,
  output logic [dbba_pkg::BLK_W-1:0]       out_run_start,
  output logic                             out_last,
  input  wire logic                        cfg_we,
  input  wire logic [dbba_pkg::REQ_W-1:0]  cfg_wdata
);

  localparam int AW = (DISK_BLOCKS > 1) ? $clog2(DISK_BLOCKS) : 1;
  localparam int CW = $clog2(MAX_FILE_BLOCKS + 1);
  localparam int BW = dbba_pkg::BLK_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DISK_BLOCKS - 1);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_SCAN1 = 6'b000100,
    ST_FULL  = 6'b001000,
    ST_SCAN2 = 6'b010000,
    ST_NOIDX = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] streak_r, streak_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] got_r, got_nxt;
  logic found_r, found_nxt;
  logic [AW-1:0] start_r, start_nxt;
  logic [dbba_pkg::REQ_W-1:0] def_req_r;

  logic out_valid_r, out_valid_nxt;
  dbba_pkg::kind_t kind_r, kind_nxt;
  logic [BW-1:0] blk_r, blk_nxt;
  logic cfound_r, cfound_nxt;
  logic [BW-1:0] cstart_r, cstart_nxt;
  logic last_r, last_nxt;

  logic map_we, map_wdata, map_rdata;
  logic [AW-1:0] map_waddr;

  logic slot_ok, accept, blk_free;
  logic [CW-1:0] req_n, cnt_inc;

  dbba_map #(
    .DEPTH(DISK_BLOCKS),
    .AW(AW)
  ) u_map (
    .clk(clk),
    .we(map_we),
    .waddr(map_waddr),
    .wdata(map_wdata),
    .raddr(ptr_nxt),
    .rdata(map_rdata)
  );

  assign slot_ok = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == ST_IDLE) && slot_ok);
  assign accept = in_valid && !in_stall;
  assign blk_free = !map_rdata;

  // effective request size
  always_comb begin
    if ((in_request_count == '0) || (32'(in_request_count) > 32'(MAX_FILE_BLOCKS))) begin
      if (def_req_r == '0) begin
        req_n = CW'(1);
      end else if (32'(def_req_r) > 32'(MAX_FILE_BLOCKS)) begin
        req_n = CW'(MAX_FILE_BLOCKS);
      end else begin
        req_n = CW'(def_req_r);
      end
    end else begin
      req_n = CW'(in_request_count);
    end
  end

  assign cnt_inc = (blk_free && (cnt_r < n_r)) ? CW'(cnt_r + CW'(1)) : cnt_r;

  always_comb begin
    state_nxt = state_r;
    ptr_nxt = ptr_r;
    n_nxt = n_r;
    streak_nxt = streak_r;
    cnt_nxt = cnt_r;
    got_nxt = got_r;
    found_nxt = found_r;
    start_nxt = start_r;
    map_we = 1'b0;
    map_waddr = ptr_r;
    map_wdata = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    kind_nxt = kind_r;
    blk_nxt = blk_r;
    cfound_nxt = cfound_r;
    cstart_nxt = cstart_r;
    last_nxt = last_r;

    case (state_r)
      ST_CLEAR: begin
        map_we = 1'b1;
        if (ptr_r == LAST_ADDR) begin
          ptr_nxt = '0;
          state_nxt = ST_IDLE;
        end else begin
          ptr_nxt = ptr_r + AW'(1);
        end
      end

      ST_IDLE: begin
        ptr_nxt = '0;
        if (accept) begin
          if (in_func == dbba_pkg::FUNC_FREE) begin
            map_we = 32'(in_free_block) < 32'(DISK_BLOCKS);
            map_waddr = AW'(in_free_block);
            map_wdata = 1'b0;
            out_valid_nxt = 1'b1;
            kind_nxt = dbba_pkg::KIND_FREED;
            blk_nxt = in_free_block;
            cfound_nxt = 1'b0;
            cstart_nxt = '0;
            last_nxt = 1'b1;
          end else begin
            n_nxt = req_n;
            streak_nxt = '0;
            cnt_nxt = '0;
            found_nxt = 1'b0;
            start_nxt = '0;
            state_nxt = ST_SCAN1;
          end
        end
      end

      // run search and free count in one pass
      ST_SCAN1: begin
        if (blk_free) begin
          if (streak_r < n_r) begin
            streak_nxt = CW'(streak_r + CW'(1));
          end
          if (!found_r && (CW'(streak_r + CW'(1)) == n_r)) begin
            found_nxt = 1'b1;
            start_nxt = ptr_r - AW'(n_r) + AW'(1);
          end
        end else begin
          streak_nxt = '0;
        end
        cnt_nxt = cnt_inc;
        if (ptr_r == LAST_ADDR) begin
          ptr_nxt = '0;
          got_nxt = '0;
          state_nxt = (cnt_inc < n_r) ? ST_FULL : ST_SCAN2;
        end else begin
          ptr_nxt = ptr_r + AW'(1);
        end
      end

      ST_FULL: begin
        if (slot_ok) begin
          out_valid_nxt = 1'b1;
          kind_nxt = dbba_pkg::KIND_FULL;
          blk_nxt = '0;
          cfound_nxt = found_r;
          cstart_nxt = BW'(start_r);
          last_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      // mark the lowest free blocks, then the index block
      ST_SCAN2: begin
        if (!blk_free || slot_ok) begin
          if (blk_free) begin
            map_we = 1'b1;
            map_wdata = 1'b1;
            out_valid_nxt = 1'b1;
            blk_nxt = BW'(ptr_r);
            cfound_nxt = found_r;
            cstart_nxt = BW'(start_r);
            if (got_r < n_r) begin
              kind_nxt = dbba_pkg::KIND_DATA;
              last_nxt = 1'b0;
              got_nxt = CW'(got_r + CW'(1));
            end else begin
              kind_nxt = dbba_pkg::KIND_INDEX;
              last_nxt = 1'b1;
            end
          end
          if (blk_free && (got_r == n_r)) begin
            ptr_nxt = '0;
            state_nxt = ST_IDLE;
          end else if (ptr_r == LAST_ADDR) begin
            ptr_nxt = '0;
            state_nxt = ST_NOIDX;
          end else begin
            ptr_nxt = ptr_r + AW'(1);
          end
        end
      end

      ST_NOIDX: begin
        if (slot_ok) begin
          out_valid_nxt = 1'b1;
          kind_nxt = dbba_pkg::KIND_NOINDEX;
          blk_nxt = '0;
          cfound_nxt = found_r;
          cstart_nxt = BW'(start_r);
          last_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
        ptr_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      ptr_r <= '0;
      out_valid_r <= 1'b0;
      def_req_r <= dbba_pkg::DEF_REQ_RST;
    end else begin
      state_r <= state_nxt;
      ptr_r <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        def_req_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r <= n_nxt;
    streak_r <= streak_nxt;
    cnt_r <= cnt_nxt;
    got_r <= got_nxt;
    found_r <= found_nxt;
    start_r <= start_nxt;
    kind_r <= kind_nxt;
    blk_r <= blk_nxt;
    cfound_r <= cfound_nxt;
    cstart_r <= cstart_nxt;
    last_r <= last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_kind = kind_r;
  assign out_block_number = blk_r;
  assign out_contig_found = cfound_r;
  assign out_run_start = cstart_r;
  assign out_last = last_r;

`ifndef SYNTHESIS
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (last_r == (kind_r != dbba_pkg::KIND_DATA)))
    else $error("last flag does not match result kind");

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> (!out_valid_r && in_stall))
    else $error("activity during map clearing pass");

  a_got_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN2) |-> (got_r <= n_r))
    else $error("more data blocks than requested");

  a_full_no_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (kind_r == dbba_pkg::KIND_FULL)) |-> !cfound_r)
    else $error("disk full reported with a free run found");

  a_run_fits: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SCAN2) && found_r) |->
      (32'(start_r) + 32'(n_r) <= 32'(DISK_BLOCKS)))
    else $error("contiguous run runs past the disk");
`endif

endmodule

`default_nettype wire

FILE: hdl/dbba_map.sv
// dbba_map: used/free bit memory, one write port and one registered read port
// depends on nothing; instantiated by disk_block_bitmap_allocator_core
`default_nettype none

module dbba_map #(
  parameter int DEPTH = 64,
  parameter int AW = 6
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic          wdata,
  input  wire logic [AW-1:0] raddr,
  output logic               rdata
);

  logic mem [DEPTH];
  logic rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire
